/* rtl/core/ffga_pkg.sv */
// Shared constants and types for the face flux gradient accumulator.
// No dependencies; imported by the top level and by its port checker.
package ffga_pkg;

    // Mesh size and derived address width.
    localparam int CELL_COUNT = 1024;
    localparam int CELL_AW    = $clog2(CELL_COUNT);

    // Accumulator width (signed, Q16.16 scale).
    localparam int ACC_W = 48;

    // Item opcodes.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_FACE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // One row of the accumulator memory.
    typedef struct packed {
        logic                    clip;
        logic signed [ACC_W-1:0] z;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] x;
    } acc_row_t;

    // Result of a saturating accumulator update.
    typedef struct packed {
        logic                    clip;
        logic signed [ACC_W-1:0] val;
    } acc_sum_t;

endpackage

/* rtl/core/face_flux_gradient_accumulator.sv */
// Top level of the Green-Gauss face flux gradient accumulator.
// Depends on ffga_pkg for constants, opcodes and memory row types.

// After reset the block sweeps its accumulator memory to zero, one cell per
// cycle, with in_ready low. A load transaction then completes in S_IDLE as it
// is accepted. An interior face skips the division when both cell volumes are
// zero, and a read may also wait for the output register to drain. Products
// and quotients come from a single shift-add multiplier and restoring divider
// that retires one bit per cycle and is reused for every product and quotient
// of an item; the block works on one transaction at a time.
module face_flux_gradient_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [9:0]  cell_index,
    input  logic [9:0]  second_cell,
    input  logic        is_boundary,
    input  logic signed [31:0] cell_value,
    input  logic [31:0] cell_volume,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [31:0] face_area,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  read_cell,
    output logic signed [31:0] grad_x,
    output logic signed [31:0] grad_y,
    output logic signed [31:0] grad_z,
    output logic        saturated
);
    import ffga_pkg::*;

    // Sequencer states.
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] F_P1    = 5'd2;
    localparam logic [4:0] F_P2    = 5'd3;
    localparam logic [4:0] F_MM    = 5'd4;
    localparam logic [4:0] F_MDS   = 5'd5;
    localparam logic [4:0] F_MD    = 5'd6;
    localparam logic [4:0] F_MF    = 5'd7;
    localparam logic [4:0] F_WS    = 5'd8;
    localparam logic [4:0] F_WM    = 5'd9;
    localparam logic [4:0] F_WF    = 5'd10;
    localparam logic [4:0] F_DS    = 5'd11;
    localparam logic [4:0] F_DM    = 5'd12;
    localparam logic [4:0] F_DF    = 5'd13;
    localparam logic [4:0] F_A1W   = 5'd14;
    localparam logic [4:0] F_A2    = 5'd15;
    localparam logic [4:0] F_A2W   = 5'd16;
    localparam logic [4:0] R_CAP   = 5'd17;
    localparam logic [4:0] R_SET   = 5'd18;
    localparam logic [4:0] R_DIV   = 5'd19;
    localparam logic [4:0] R_FIN   = 5'd20;
    localparam logic [4:0] R_OUT   = 5'd21;

    localparam logic [5:0] MUL_LAST  = 6'd31;
    localparam logic [5:0] FDIV_LAST = 6'd31;
    localparam logic [5:0] RDIV_LAST = 6'd32;

    // Control state.
    logic [4:0]         state_reg, state_next;
    logic [CELL_AW-1:0] clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;

    // Latched transaction fields.
    logic [9:0]         c1_reg, c1_next;
    logic [9:0]         c2_reg, c2_next;
    logic               bnd_reg, bnd_next;
    logic               ok_reg, ok_next;
    logic signed [15:0] nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic [31:0]        area_reg, area_next;

    // Working registers.
    logic [5:0]         cnt_reg, cnt_next;
    logic [1:0]         k_reg, k_next;
    logic signed [31:0] p1_reg, p1_next;
    logic [31:0]        v1_reg, v1_next;
    logic signed [31:0] lo_reg, lo_next;
    logic signed [31:0] m_reg, m_next;
    logic signed [48:0] w_reg, w_next;
    logic signed [49:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic signed [47:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic               sat_reg, sat_next;
    logic [31:0]        gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;

    // Shared multiply/divide unit registers.
    logic [79:0]        mul_reg, mul_next;
    logic [47:0]        mca_reg, mca_next;
    logic               neg_reg, neg_next;
    logic [32:0]        rem_reg, rem_next;
    logic [32:0]        dvd_reg, dvd_next;
    logic [32:0]        div_reg, div_next;

    // Output register.
    logic [9:0]         read_cell_reg, read_cell_next;
    logic [31:0]        grad_x_reg, grad_x_next, grad_y_reg, grad_y_next;
    logic [31:0]        grad_z_reg, grad_z_next;
    logic               saturated_reg, saturated_next;

    // Memories and their ports.
    logic [63:0]        vv_mem [CELL_COUNT];
    acc_row_t           acc_mem [CELL_COUNT];
    logic [63:0]        vv_rdata_reg;
    acc_row_t           acc_rdata_reg;
    logic               vv_we, vv_re, acc_we, acc_re;
    logic [CELL_AW-1:0] vv_waddr, vv_raddr, acc_waddr, acc_raddr;
    logic [63:0]        vv_wdata;
    acc_row_t           acc_wdata;

    // Shared unit combinational step.
    logic [48:0]        mul_sum;
    logic [79:0]        mul_step;
    logic [33:0]        div_t;
    logic               div_ge;
    logic [33:0]        div_rem;
    logic signed [64:0] prod_s;
    logic signed [64:0] prod_sh16, prod_sh14;

    // Helpers for face and read steps.
    logic signed [31:0] rd_val;
    logic [31:0]        rd_vol;
    logic [32:0]        vsum;
    logic signed [32:0] pdiff;
    logic signed [32:0] m_neg;
    logic signed [49:0] w_neg;
    logic signed [15:0] n_sel;
    logic signed [16:0] n_mag;
    logic signed [47:0] a_sel;
    logic signed [48:0] a_mag49;
    logic [47:0]        a_mag;
    logic [31:0]        g_fin;
    logic               g_fin_sat;
    acc_sum_t           sx, sy, sz;
    logic               accept;

    // Saturating add or subtract of a contribution into an accumulator.
    function automatic acc_sum_t sat_acc(input logic signed [47:0] a,
                                         input logic signed [49:0] d,
                                         input logic sub);
        logic signed [50:0] ae;
        logic signed [50:0] de;
        logic signed [50:0] s;
        acc_sum_t           r;
        ae = {{3{a[47]}}, a};
        de = {d[49], d};
        s  = sub ? (ae - de) : (ae + de);
        if (s[50:47] == 4'b0000 || s[50:47] == 4'b1111) begin
            r.clip = 1'b0;
            r.val  = s[47:0];
        end else begin
            r.clip = 1'b1;
            r.val  = s[50] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    // Apply a sign to a 64-bit magnitude.
    function automatic logic signed [64:0] apply_sign(input logic [63:0] p,
                                                      input logic neg);
        logic signed [64:0] v;
        v = $signed({1'b0, p});
        return neg ? -v : v;
    endfunction

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // One bit per cycle shift-add multiply and restoring divide.
    assign mul_sum  = {1'b0, mul_reg[79:32]} + (mul_reg[0] ? {1'b0, mca_reg} : 49'd0);
    assign mul_step = {mul_sum, mul_reg[31:1]};
    assign div_t    = {rem_reg, dvd_reg[32]};
    assign div_ge   = (div_t >= {1'b0, div_reg});
    assign div_rem  = div_ge ? (div_t - {1'b0, div_reg}) : div_t;
    assign prod_s    = apply_sign(mul_reg[63:0], neg_reg);
    assign prod_sh16 = prod_s >>> 16;
    assign prod_sh14 = prod_s >>> 14;

    // Operand views.
    assign rd_val  = vv_rdata_reg[31:0];
    assign rd_vol  = vv_rdata_reg[63:32];
    assign vsum    = {1'b0, v1_reg} + {1'b0, rd_vol};
    assign pdiff   = {rd_val[31], rd_val} - {p1_reg[31], p1_reg};
    assign m_neg   = -{m_reg[31], m_reg};
    assign w_neg   = -{w_reg[48], w_reg};
    assign a_mag49 = a_sel[47] ? -{a_sel[47], a_sel} : {a_sel[47], a_sel};
    assign a_mag   = a_mag49[47:0];
    assign n_mag   = n_sel[15] ? -{n_sel[15], n_sel} : {n_sel[15], n_sel};

    // Component selection.
    always_comb
    begin
        unique case (k_reg)
            2'd0:    begin n_sel = nx_reg; a_sel = ax_reg; end
            2'd1:    begin n_sel = ny_reg; a_sel = ay_reg; end
            default: begin n_sel = nz_reg; a_sel = az_reg; end
        endcase
    end

    // Final saturation of a read quotient.
    always_comb
    begin
        g_fin_sat = 1'b0;
        if (neg_reg) begin
            if (dvd_reg > 33'h080000000) begin
                g_fin     = 32'h80000000;
                g_fin_sat = 1'b1;
            end else begin
                g_fin = 32'd0 - dvd_reg[31:0];
            end
        end else begin
            if (dvd_reg > 33'h07FFFFFFF) begin
                g_fin     = 32'h7FFFFFFF;
                g_fin_sat = 1'b1;
            end else begin
                g_fin = dvd_reg[31:0];
            end
        end
    end

    // Accumulator updates for the first and second cell.
    assign sx = sat_acc(acc_rdata_reg.x, dx_reg, (state_reg == F_A2W));
    assign sy = sat_acc(acc_rdata_reg.y, dy_reg, (state_reg == F_A2W));
    assign sz = sat_acc(acc_rdata_reg.z, dz_reg, (state_reg == F_A2W));

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        c1_next = c1_reg;  c2_next = c2_reg;  bnd_next = bnd_reg;  ok_next = ok_reg;
        nx_next = nx_reg;  ny_next = ny_reg;  nz_next = nz_reg;  area_next = area_reg;
        cnt_next = cnt_reg;  k_next = k_reg;
        p1_next = p1_reg;  v1_next = v1_reg;  lo_next = lo_reg;  m_next = m_reg;
        w_next = w_reg;  dx_next = dx_reg;  dy_next = dy_reg;  dz_next = dz_reg;
        ax_next = ax_reg;  ay_next = ay_reg;  az_next = az_reg;  sat_next = sat_reg;
        gx_next = gx_reg;  gy_next = gy_reg;  gz_next = gz_reg;
        mul_next = mul_reg;  mca_next = mca_reg;  neg_next = neg_reg;
        rem_next = rem_reg;  dvd_next = dvd_reg;  div_next = div_reg;
        read_cell_next = read_cell_reg;
        grad_x_next = grad_x_reg;  grad_y_next = grad_y_reg;  grad_z_next = grad_z_reg;
        saturated_next = saturated_reg;
        vv_we = 1'b0;  vv_re = 1'b0;  acc_we = 1'b0;  acc_re = 1'b0;
        vv_waddr  = CELL_AW'(cell_index);
        vv_raddr  = CELL_AW'(cell_index);
        acc_waddr = CELL_AW'(c1_reg);
        acc_raddr = CELL_AW'(cell_index);
        vv_wdata  = {cell_volume, cell_value};
        acc_wdata = '0;

        unique case (state_reg)
            // Zero the accumulator memory after reset.
            S_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == CELL_COUNT - 1) begin
                    state_next = S_IDLE;
                end
            end

            // Accept a transaction; loads complete here.
            S_IDLE:
            begin
                if (accept) begin
                    c1_next   = cell_index;
                    c2_next   = second_cell;
                    bnd_next  = is_boundary;
                    nx_next   = normal_x;
                    ny_next   = normal_y;
                    nz_next   = normal_z;
                    area_next = face_area;
                    unique case (opcode)
                        OP_LOAD:
                        begin
                            if (32'(cell_index) < CELL_COUNT) begin
                                vv_we     = 1'b1;
                                acc_we    = 1'b1;
                                acc_waddr = CELL_AW'(cell_index);
                            end
                        end
                        OP_FACE:
                        begin
                            vv_re   = 1'b1;
                            ok_next = (32'(cell_index) < CELL_COUNT) &&
                                      (is_boundary || (32'(second_cell) < CELL_COUNT));
                            state_next = F_P1;
                        end
                        OP_READ:
                        begin
                            vv_re      = 1'b1;
                            acc_re     = 1'b1;
                            ok_next    = (32'(cell_index) < CELL_COUNT);
                            state_next = R_CAP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // First cell operands.
            F_P1:
            begin
                p1_next = rd_val;
                v1_next = rd_vol;
                if (!ok_reg) begin
                    state_next = S_IDLE;
                end else if (bnd_reg) begin
                    m_next     = rd_val;
                    state_next = F_WS;
                end else begin
                    vv_re      = 1'b1;
                    vv_raddr   = CELL_AW'(c2_reg);
                    state_next = F_P2;
                end
            end

            // Second cell operands; start diff * heavier-side volume.
            F_P2:
            begin
                if (vsum == 33'd0) begin
                    m_next     = p1_reg;
                    state_next = F_WS;
                end else begin
                    div_next = vsum;
                    cnt_next = 6'd0;
                    if (!pdiff[32]) begin
                        lo_next  = p1_reg;
                        mca_next = {16'd0, pdiff[31:0]};
                        mul_next = {48'd0, rd_vol};
                    end else begin
                        lo_next  = rd_val;
                        mca_next = {16'd0, 32'd0 - pdiff[31:0]};
                        mul_next = {48'd0, v1_reg};
                    end
                    state_next = F_MM;
                end
            end

            F_MM:
            begin
                mul_next = mul_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = F_MDS;
                end
            end

            // Quotient fits 32 bits, so the upper half seeds the remainder.
            F_MDS:
            begin
                rem_next   = {1'b0, mul_reg[63:32]};
                dvd_next   = {mul_reg[31:0], 1'b0};
                cnt_next   = 6'd0;
                state_next = F_MD;
            end

            F_MD:
            begin
                rem_next = div_rem[32:0];
                dvd_next = {dvd_reg[31:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == FDIV_LAST) begin
                    state_next = F_MF;
                end
            end

            F_MF:
            begin
                m_next     = 32'($signed({lo_reg[31], lo_reg}) + $signed({1'b0, dvd_reg[31:0]}));
                state_next = F_WS;
            end

            // Face weight: mean times area.
            F_WS:
            begin
                mca_next   = {16'd0, m_reg[31] ? m_neg[31:0] : m_reg};
                mul_next   = {48'd0, area_reg};
                neg_next   = m_reg[31];
                cnt_next   = 6'd0;
                state_next = F_WM;
            end

            F_WM:
            begin
                mul_next = mul_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = F_WF;
                end
            end

            F_WF:
            begin
                w_next     = prod_sh16[48:0];
                k_next     = 2'd0;
                state_next = F_DS;
            end

            // Contribution per component: weight times normal.
            F_DS:
            begin
                mca_next   = w_reg[48] ? w_neg[47:0] : w_reg[47:0];
                mul_next   = {48'd0, 16'd0, n_mag[15:0]};
                neg_next   = w_reg[48] ^ n_sel[15];
                cnt_next   = 6'd0;
                state_next = F_DM;
            end

            F_DM:
            begin
                mul_next = mul_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = F_DF;
                end
            end

            F_DF:
            begin
                unique case (k_reg)
                    2'd0:    dx_next = prod_sh14[49:0];
                    2'd1:    dy_next = prod_sh14[49:0];
                    default: dz_next = prod_sh14[49:0];
                endcase
                if (k_reg == 2'd2) begin
                    acc_re     = 1'b1;
                    acc_raddr  = CELL_AW'(c1_reg);
                    state_next = F_A1W;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = F_DS;
                end
            end

            // Add into the first cell.
            F_A1W:
            begin
                acc_we         = 1'b1;
                acc_waddr      = CELL_AW'(c1_reg);
                acc_wdata.x    = sx.val;
                acc_wdata.y    = sy.val;
                acc_wdata.z    = sz.val;
                acc_wdata.clip = acc_rdata_reg.clip | sx.clip | sy.clip | sz.clip;
                state_next     = bnd_reg ? S_IDLE : F_A2;
            end

            F_A2:
            begin
                acc_re     = 1'b1;
                acc_raddr  = CELL_AW'(c2_reg);
                state_next = F_A2W;
            end

            // Subtract from the second cell.
            F_A2W:
            begin
                acc_we         = 1'b1;
                acc_waddr      = CELL_AW'(c2_reg);
                acc_wdata.x    = sx.val;
                acc_wdata.y    = sy.val;
                acc_wdata.z    = sz.val;
                acc_wdata.clip = acc_rdata_reg.clip | sx.clip | sy.clip | sz.clip;
                state_next     = S_IDLE;
            end

            // Capture the cell row for a read.
            R_CAP:
            begin
                v1_next  = rd_vol;
                ax_next  = acc_rdata_reg.x;
                ay_next  = acc_rdata_reg.y;
                az_next  = acc_rdata_reg.z;
                k_next   = 2'd0;
                if (ok_reg) begin
                    sat_next   = acc_rdata_reg.clip;
                    state_next = R_SET;
                end else begin
                    sat_next   = 1'b0;
                    gx_next    = 32'd0;
                    gy_next    = 32'd0;
                    gz_next    = 32'd0;
                    state_next = R_OUT;
                end
            end

            // Per component: trivial cases, or start a division.
            R_SET:
            begin
                if (a_mag == 48'd0 || {1'b0, a_mag[47:17]} >= v1_reg) begin
                    unique case (k_reg)
                        2'd0:    gx_next = (a_mag == 48'd0) ? 32'd0 :
                                           (a_sel[47] ? 32'h80000000 : 32'h7FFFFFFF);
                        2'd1:    gy_next = (a_mag == 48'd0) ? 32'd0 :
                                           (a_sel[47] ? 32'h80000000 : 32'h7FFFFFFF);
                        default: gz_next = (a_mag == 48'd0) ? 32'd0 :
                                           (a_sel[47] ? 32'h80000000 : 32'h7FFFFFFF);
                    endcase
                    if (a_mag != 48'd0) begin
                        sat_next = 1'b1;
                    end
                    if (k_reg == 2'd2) begin
                        state_next = R_OUT;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end else begin
                    rem_next   = {2'b00, a_mag[47:17]};
                    dvd_next   = {a_mag[16:0], 16'd0};
                    div_next   = {1'b0, v1_reg};
                    neg_next   = a_sel[47];
                    cnt_next   = 6'd0;
                    state_next = R_DIV;
                end
            end

            R_DIV:
            begin
                rem_next = div_rem[32:0];
                dvd_next = {dvd_reg[31:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == RDIV_LAST) begin
                    state_next = R_FIN;
                end
            end

            R_FIN:
            begin
                unique case (k_reg)
                    2'd0:    gx_next = g_fin;
                    2'd1:    gy_next = g_fin;
                    default: gz_next = g_fin;
                endcase
                if (g_fin_sat) begin
                    sat_next = 1'b1;
                end
                if (k_reg == 2'd2) begin
                    state_next = R_OUT;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = R_SET;
                end
            end

            // Hand the result to the output register once it is free.
            R_OUT:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    read_cell_next = c1_reg;
                    grad_x_next    = gx_reg;
                    grad_y_next    = gy_reg;
                    grad_z_next    = gz_reg;
                    saturated_next = sat_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        c1_reg <= c1_next;  c2_reg <= c2_next;  bnd_reg <= bnd_next;  ok_reg <= ok_next;
        nx_reg <= nx_next;  ny_reg <= ny_next;  nz_reg <= nz_next;  area_reg <= area_next;
        cnt_reg <= cnt_next;  k_reg <= k_next;
        p1_reg <= p1_next;  v1_reg <= v1_next;  lo_reg <= lo_next;  m_reg <= m_next;
        w_reg <= w_next;  dx_reg <= dx_next;  dy_reg <= dy_next;  dz_reg <= dz_next;
        ax_reg <= ax_next;  ay_reg <= ay_next;  az_reg <= az_next;  sat_reg <= sat_next;
        gx_reg <= gx_next;  gy_reg <= gy_next;  gz_reg <= gz_next;
        mul_reg <= mul_next;  mca_reg <= mca_next;  neg_reg <= neg_next;
        rem_reg <= rem_next;  dvd_reg <= dvd_next;  div_reg <= div_next;
        read_cell_reg <= read_cell_next;
        grad_x_reg <= grad_x_next;  grad_y_reg <= grad_y_next;  grad_z_reg <= grad_z_next;
        saturated_reg <= saturated_next;
    end

    // Value and volume memory.
    always_ff @(posedge clk)
    begin
        if (vv_we) begin
            vv_mem[vv_waddr] <= vv_wdata;
        end
        if (vv_re) begin
            vv_rdata_reg <= vv_mem[vv_raddr];
        end
    end

    // Accumulator memory.
    always_ff @(posedge clk)
    begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (acc_re) begin
            acc_rdata_reg <= acc_mem[acc_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign read_cell = read_cell_reg;
    assign grad_x    = grad_x_reg;
    assign grad_y    = grad_y_reg;
    assign grad_z    = grad_z_reg;
    assign saturated = saturated_reg;

endmodule

/* rtl/core/ffga_check.sv */
// Port-level checker for the face flux gradient accumulator, with its bind.
// Depends on ffga_pkg for opcodes.
module ffga_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  read_cell,
    input logic [31:0] grad_x,
    input logic [31:0] grad_y,
    input logic [31:0] grad_z,
    input logic        saturated
);
    import ffga_pkg::*;

    // Face and read transactions keep the block busy on the next cycle.
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_FACE || opcode == OP_READ) |=> !in_ready)
        else $error("block ready right after accepting a face or read");

    // A read result never appears the cycle after the read is accepted.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_READ |=> !$rose(out_valid))
        else $error("read result appeared too early");

    // A new result is only produced while the block is busy.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the block was idle");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_cell) && $stable(grad_x)
            && $stable(grad_y) && $stable(grad_z) && $stable(saturated))
        else $error("stalled result changed");

endmodule

bind face_flux_gradient_accumulator ffga_check u_ffga_check (.*);

/* tb/sv/face_flux_gradient_accumulator_tb.sv */
// Self-checking testbench for the face flux gradient accumulator.
// Depends on ffga_pkg and the face_flux_gradient_accumulator RTL; no other files.
`timescale 1ns / 1ps

module face_flux_gradient_accumulator_tb;
    import ffga_pkg::*;

    localparam longint ACC_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO    = -ACC_HI - 1;
    localparam int     RUN_LIMIT = 2000000;
    localparam int     TAIL_WAIT = 300;
    localparam int     MAX_SHOWN = 10;

    typedef struct {
        logic [1:0]         op;
        logic [9:0]         c1;
        logic [9:0]         c2;
        logic               bnd;
        logic signed [31:0] val;
        logic [31:0]        vol;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [31:0]        area;
    } face_item_t;

    typedef struct {
        logic [9:0]         cell_idx;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic               sat;
    } grad_result_t;

    // Gradient predictor and result store.
    class grad_scoreboard;
        logic [31:0]  cell_val [CELL_COUNT];
        logic [31:0]  cell_vol [CELL_COUNT];
        longint       acc_x [CELL_COUNT];
        longint       acc_y [CELL_COUNT];
        longint       acc_z [CELL_COUNT];
        bit           clip [CELL_COUNT];
        grad_result_t pending_grads[$];
        int           mismatches;

        function new();
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                cell_val[i] = '0;
                cell_vol[i] = '0;
                acc_x[i] = 0;
                acc_y[i] = 0;
                acc_z[i] = 0;
                clip[i] = 0;
            end
            mismatches = 0;
        endfunction

        function longint clamp_add(longint a, longint d, ref bit f);
            longint s;
            s = a + d;
            if (s > ACC_HI)
            begin
                s = ACC_HI;
                f = 1;
            end
            if (s < ACC_LO)
            begin
                s = ACC_LO;
                f = 1;
            end
            return s;
        endfunction

        // Quotient of accumulator over volume, truncated and clipped to Q16.16.
        function logic [31:0] divide_comp(longint a, logic [31:0] vol, ref bit sat);
            longint unsigned mag;
            longint unsigned q;
            mag = (a < 0) ? longint'(-a) : longint'(a);
            if (mag == 0)
                return 32'd0;
            if (vol == 0)
            begin
                sat = 1;
                return (a < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            q = (mag << 16) / {32'd0, vol};
            if (a < 0)
            begin
                if (q > 64'h8000_0000)
                begin
                    q = 64'h8000_0000;
                    sat = 1;
                end
                return 32'd0 - q[31:0];
            end
            if (q > 64'h7FFF_FFFF)
            begin
                q = 64'h7FFF_FFFF;
                sat = 1;
            end
            return q[31:0];
        endfunction

        // Update the mesh state for one accepted input transaction.
        function void note_input(face_item_t it);
            longint          p1, p2, lo, m, w, dx, dy, dz;
            longint unsigned diff, vh, vsum;
            grad_result_t    r;
            bit              s;
            case (it.op)
                OP_LOAD:
                begin
                    cell_val[it.c1] = it.val;
                    cell_vol[it.c1] = it.vol;
                    acc_x[it.c1] = 0;
                    acc_y[it.c1] = 0;
                    acc_z[it.c1] = 0;
                    clip[it.c1] = 0;
                end
                OP_FACE:
                begin
                    p1 = longint'($signed(cell_val[it.c1]));
                    m = p1;
                    if (!it.bnd)
                    begin
                        p2 = longint'($signed(cell_val[it.c2]));
                        vsum = {32'd0, cell_vol[it.c1]} + {32'd0, cell_vol[it.c2]};
                        if (vsum != 0)
                        begin
                            if (p1 <= p2)
                            begin
                                lo = p1;
                                diff = p2 - p1;
                                vh = {32'd0, cell_vol[it.c2]};
                            end
                            else
                            begin
                                lo = p2;
                                diff = p1 - p2;
                                vh = {32'd0, cell_vol[it.c1]};
                            end
                            m = lo + longint'((diff * vh) / vsum);
                        end
                    end
                    w = (m * longint'({32'd0, it.area})) >>> 16;
                    dx = (w * longint'(it.nx)) >>> 14;
                    dy = (w * longint'(it.ny)) >>> 14;
                    dz = (w * longint'(it.nz)) >>> 14;
                    acc_x[it.c1] = clamp_add(acc_x[it.c1], dx, clip[it.c1]);
                    acc_y[it.c1] = clamp_add(acc_y[it.c1], dy, clip[it.c1]);
                    acc_z[it.c1] = clamp_add(acc_z[it.c1], dz, clip[it.c1]);
                    if (!it.bnd)
                    begin
                        acc_x[it.c2] = clamp_add(acc_x[it.c2], -dx, clip[it.c2]);
                        acc_y[it.c2] = clamp_add(acc_y[it.c2], -dy, clip[it.c2]);
                        acc_z[it.c2] = clamp_add(acc_z[it.c2], -dz, clip[it.c2]);
                    end
                end
                OP_READ:
                begin
                    s = clip[it.c1];
                    r.cell_idx = it.c1;
                    r.gx = divide_comp(acc_x[it.c1], cell_vol[it.c1], s);
                    r.gy = divide_comp(acc_y[it.c1], cell_vol[it.c1], s);
                    r.gz = divide_comp(acc_z[it.c1], cell_vol[it.c1], s);
                    r.sat = s;
                    pending_grads.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compare one output transaction with the oldest expected gradient.
        function void check_result(grad_result_t got);
            grad_result_t exp_r;
            if (pending_grads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: unexpected gradient for cell %0d", got.cell_idx);
                return;
            end
            exp_r = pending_grads.pop_front();
            if (got.cell_idx !== exp_r.cell_idx || got.gx !== exp_r.gx
                || got.gy !== exp_r.gy || got.gz !== exp_r.gz || got.sat !== exp_r.sat)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: cell %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d sat %0b/%0b",
                             exp_r.cell_idx, got.cell_idx, exp_r.gx, got.gx, exp_r.gy,
                             got.gy, exp_r.gz, got.gz, exp_r.sat, got.sat);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [9:0]         cell_index;
    logic [9:0]         second_cell;
    logic               is_boundary;
    logic signed [31:0] cell_value;
    logic [31:0]        cell_volume;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        face_area;
    logic               out_valid;
    logic               out_ready;
    logic [9:0]         read_cell;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               saturated;

    grad_scoreboard sb = new();
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_left;
    bit             hold_req;
    int             cycle_count;
    bit             loaded [CELL_COUNT];
    int             loaded_list[$];

    face_flux_gradient_accumulator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .cell_index  (cell_index),
        .second_cell (second_cell),
        .is_boundary (is_boundary),
        .cell_value  (cell_value),
        .cell_volume (cell_volume),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .face_area   (face_area),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_cell   (read_cell),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .saturated   (saturated)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("face_flux_gradient_accumulator_tb failed");
            $finish;
        end
    end

    // Result side: check accepted transactions and drive out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                sb.check_result('{read_cell, grad_x, grad_y, grad_z, saturated});
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one transaction and wait until it is accepted.
    task automatic send_item(face_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= it.op;
        cell_index  <= it.c1;
        second_cell <= it.c2;
        is_boundary <= it.bnd;
        cell_value  <= it.val;
        cell_volume <= it.vol;
        normal_x    <= it.nx;
        normal_y    <= it.ny;
        normal_z    <= it.nz;
        face_area   <= it.area;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(it);
        if (it.op == OP_LOAD && !loaded[it.c1])
        begin
            loaded[it.c1] = 1;
            loaded_list.push_back(int'(it.c1));
        end
    endtask

    task automatic send_op(logic [1:0] op, int c1, int c2, bit bnd, logic [31:0] val,
                           logic [31:0] vol, int nx, int ny, int nz, logic [31:0] area);
        face_item_t it;
        it = '{op, 10'(c1), 10'(c2), bnd, val, vol, 16'(nx), 16'(ny), 16'(nz), area};
        send_item(it);
    endtask

    // Wide-ranging 32-bit value: full random, small, or an extreme.
    function automatic logic [31:0] mixed_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h0004_0000);
            2: return 32'd0 - $urandom_range(32'h0004_0000);
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic int rand_normal();
        return $urandom_range(32768) - 16384;
    endfunction

    // One random transaction; faces and reads only touch loaded cells.
    task automatic send_random();
        face_item_t it;
        int         pick;
        pick = $urandom_range(99);
        it.c1 = 10'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        it.c2 = 10'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        it.bnd = $urandom_range(3) == 0;
        it.val = mixed_word();
        it.vol = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0008_0000, 1);
        it.nx = 16'(rand_normal());
        it.ny = 16'(rand_normal());
        it.nz = 16'(rand_normal());
        it.area = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0004_0000);
        if (pick < 18)
        begin
            it.op = OP_LOAD;
            if ($urandom_range(1))
                it.c1 = 10'($urandom_range(CELL_COUNT - 1));
        end
        else if (pick < 68)
        begin
            it.op = OP_FACE;
            if (it.bnd)
                it.c2 = 10'($urandom_range(CELL_COUNT - 1));
        end
        else if (pick < 95)
            it.op = OP_READ;
        else
        begin
            it.op = 2'd3;
            it.c1 = 10'($urandom_range(CELL_COUNT - 1));
        end
        send_item(it);
    endtask

    initial
    begin
        in_valid    <= 1'b0;
        opcode      <= OP_LOAD;
        cell_index  <= '0;
        second_cell <= '0;
        is_boundary <= 1'b0;
        cell_value  <= '0;
        cell_volume <= '0;
        normal_x    <= '0;
        normal_y    <= '0;
        normal_z    <= '0;
        face_area   <= '0;
        rst_n       <= 1'b0;
        cycle_count = 0;
        hold_req = 0;
        send_idle_pct = 11;
        recv_stall_pct = 46;
        for (int i = 0; i < CELL_COUNT; i++)
            loaded[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, zero volumes, same-cell face, clipping.
        send_op(OP_LOAD, 0, 0, 0, 32'h7FFF_FFFF, 32'd1, 0, 0, 0, 0);
        send_op(OP_LOAD, 1, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_op(OP_LOAD, 2, 0, 0, 32'd0, 32'd0, 0, 0, 0, 0);
        send_op(OP_LOAD, 3, 0, 0, 32'h0005_0000, 32'd0, 0, 0, 0, 0);
        send_op(OP_LOAD, 1023, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0, 0);
        send_op(OP_FACE, 0, 1, 0, 0, 0, 16384, -16384, 0, 32'hFFFF_FFFF);
        send_op(OP_FACE, 2, 1023, 1, 0, 0, 16384, 16384, 16384, 32'd0);
        send_op(OP_FACE, 1023, 1023, 0, 0, 0, 16384, -16384, 1, 32'h0003_0000);
        send_op(OP_FACE, 2, 3, 0, 0, 0, 16384, 16384, 16384, 32'h0001_0000);
        send_op(OP_FACE, 3, 0, 1, 0, 0, 16384, -16384, 7, 32'h0001_0000);
        send_op(OP_FACE, 0, 0, 1, 0, 0, 16384, 16384, -16384, 32'hFFFF_FFFF);
        send_op(OP_FACE, 0, 0, 1, 0, 0, 16384, 16384, -16384, 32'hFFFF_FFFF);
        send_op(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_READ, 1023, 1023, 1, 0, 0, 0, 0, 0, 0);
        send_op(2'd3, 1023, 1023, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, -1, -1, 32'hFFFF_FFFF);

        // Random phases with different idling on each side.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 46 : 0;
            recv_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 11 : 0;
            for (int k = 0; k < 24; k++)
                send_op(OP_LOAD, $urandom_range(CELL_COUNT - 1), $urandom_range(CELL_COUNT - 1),
                        1'($urandom_range(1)), mixed_word(), $urandom_range(32'h0008_0000, 1),
                        rand_normal(), rand_normal(), rand_normal(), $urandom());
            if (phase == 1)
            begin
                // Long receiver hold-off while reads keep arriving.
                hold_req = 1;
                wait (hold_left != 0);
                hold_req = 0;
                for (int k = 0; k < 6; k++)
                    send_op(OP_READ, loaded_list[$urandom_range(loaded_list.size() - 1)],
                            0, 0, 0, 0, 0, 0, 0, 0);
            end
            for (int k = 0; k < 176; k++)
                send_random();
            // Let the block drain completely before the next phase.
            in_valid <= 1'b0;
            while (sb.pending_grads.size() != 0)
                @(posedge clk);
            repeat (TAIL_WAIT) @(posedge clk);
        end

        if (sb.mismatches == 0 && sb.pending_grads.size() == 0)
            $display("face_flux_gradient_accumulator_tb passed");
        else
            $display("face_flux_gradient_accumulator_tb failed");
        $finish;
    end

endmodule
